### design/assert_macros.svh
// Assertion macros for the range sum tree module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define RSTA_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
	else $error("%m: assertion failed");
// Condition must never be true outside reset.
`define RSTA_NEVER(lbl, clk_s, rst_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
	else $error("%m: forbidden condition seen");
`else
`define RSTA_ASSERT(lbl, clk_s, rst_s, prop)
`define RSTA_NEVER(lbl, clk_s, rst_s, cond)
`endif
`endif

### design/rsta_pkg.sv
// Package with widths, codes and the controller state type of the range sum tree.
`timescale 1ns / 1ps
package rsta_pkg;

	localparam int POS_W      = 10;
	localparam int DELTA_W    = 16;
	localparam int SUM_W      = 32;
	localparam int LEAVES_DEF = 1024;

	// Item mode codes.
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_WR,
		ST_UPD_UP,
		ST_Q_RUN,
		ST_Q_EMIT
	} state_t;

endpackage

### design/rsta_ifs.sv
// Valid/ready channel interfaces for the request and response transactions.
`timescale 1ns / 1ps
interface rsta_req_if import rsta_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [POS_W-1:0]          position;
	logic [POS_W-1:0]          right;
	logic signed [DELTA_W-1:0] delta;

	modport source (output valid, mode, position, right, delta, input ready);
	modport sink (input valid, mode, position, right, delta, output ready);
endinterface

interface rsta_rsp_if import rsta_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] sum;

	modport source (output valid, sum, input ready);
	modport sink (input valid, sum, output ready);
endinterface

### design/rsta_mem.sv
// Node sum memory: one write port and two read ports with registered read data.
`timescale 1ns / 1ps
module rsta_mem import rsta_pkg::*; #(
	parameter int DEPTH = 2 * LEAVES_DEF,
	parameter int AW    = $clog2(2 * LEAVES_DEF)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [SUM_W-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [SUM_W-1:0] rdata_a,
	output logic [SUM_W-1:0] rdata_b
);

	logic [SUM_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports with registered read data.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### design/range_sum_tree_point_add.sv
// An update walks from its leaf up to the root before the next item is taken.
// A query walks the tree level by level, then shows its result and returns to take the next
// item; a result still held at the output delays the emit until the output takes it.
// One item is in work at a time; the walks handle the tree level by level through the node memory ports.
// After reset the controller sweeps the node memory to zero before it takes the first transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module range_sum_tree_point_add import rsta_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rsta_req_if.sink  req,
	rsta_rsp_if.source rsp
);

	localparam int NODES = 2 * LEAVES;
	localparam int AW    = $clog2(NODES);
	localparam int NW    = AW + 1;
	localparam int CW    = (NW > POS_W) ? NW : POS_W;

	state_t           state_q, state_d;
	logic [AW-1:0]    clr_q, clr_d;
	logic [AW-1:0]    node_q, node_d;
	logic [NW-1:0]    a_q, a_d, b_q, b_d;
	logic             ea_s1, ea_d, eb_s1, eb_d;
	logic [SUM_W-1:0] cur_q, cur_d;
	logic [DELTA_W-1:0] delta_q, delta_d;
	logic             rsp_valid_q, rsp_valid_d;
	logic [SUM_W-1:0] sum_q, sum_d;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [SUM_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

	logic             accept;
	logic [CW-1:0]    lo_w, hi_w, hi_c;
	logic             lo_out, q_empty;
	logic [AW-1:0]    leaf_idx, parent;
	logic [NW-1:0]    a_init, b_init;
	logic [SUM_W-1:0] term_a, term_b, delta_ext;

	rsta_mem #(
		.DEPTH (NODES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.sum   = sum_q;

	// Range decode of the incoming transaction: clamp right end, detect empty ranges.
	always_comb begin
		lo_w     = CW'(req.position);
		hi_w     = CW'(req.right);
		lo_out   = (lo_w >= CW'(LEAVES));
		hi_c     = (hi_w >= CW'(LEAVES)) ? CW'(LEAVES - 1) : hi_w;
		q_empty  = lo_out || (lo_w > hi_c);
		leaf_idx = AW'(lo_w + CW'(LEAVES));
		a_init   = q_empty ? '0 : NW'(lo_w + CW'(LEAVES));
		b_init   = q_empty ? '0 : NW'(hi_c + CW'(LEAVES) + CW'(1));
	end

	assign delta_ext = {{(SUM_W - DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
	assign parent    = node_q >> 1;
	assign term_a    = ea_s1 ? mem_rdata_a : '0;
	assign term_b    = eb_s1 ? mem_rdata_b : '0;

	// Controller: clearing sweep, update walk toward the root, query walk over two ends.
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		node_d      = node_q;
		a_d         = a_q;
		b_d         = b_q;
		ea_d        = ea_s1;
		eb_d        = eb_s1;
		cur_d       = cur_q;
		delta_d     = delta_q;
		sum_d       = sum_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		mem_we      = 1'b0;
		mem_waddr   = node_q;
		mem_wdata   = cur_q;
		mem_raddr_a = node_q;
		mem_raddr_b = node_q;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				clr_d     = clr_q + AW'(1);
				if (clr_q == AW'(NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				mem_raddr_a = leaf_idx;
				if (accept) begin
					if (req.mode == MODE_QUERY) begin
						a_d     = a_init;
						b_d     = b_init;
						ea_d    = 1'b0;
						eb_d    = 1'b0;
						cur_d   = '0;
						state_d = ST_Q_RUN;
					end else if (!lo_out) begin
						node_d  = leaf_idx;
						delta_d = req.delta;
						state_d = ST_UPD_WR;
					end
				end
			end
			ST_UPD_WR: begin
				// Leaf read data is back: add the delta and fetch the sibling.
				mem_we      = 1'b1;
				mem_waddr   = node_q;
				mem_wdata   = mem_rdata_a + delta_ext;
				cur_d       = mem_wdata;
				mem_raddr_a = node_q ^ AW'(1);
				state_d     = ST_UPD_UP;
			end
			ST_UPD_UP: begin
				// Parent gets this node plus its sibling; fetch the parent's sibling.
				mem_we      = 1'b1;
				mem_waddr   = parent;
				mem_wdata   = cur_q + mem_rdata_a;
				cur_d       = mem_wdata;
				node_d      = parent;
				mem_raddr_a = parent ^ AW'(1);
				if (parent == AW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_Q_RUN: begin
				// Accumulate the nodes read last cycle, then issue the next level.
				cur_d       = cur_q + term_a + term_b;
				mem_raddr_a = a_q[AW-1:0];
				mem_raddr_b = AW'(b_q - NW'(1));
				if (a_q < b_q) begin
					ea_d = a_q[0];
					eb_d = b_q[0];
					a_d  = (a_q + NW'(a_q[0])) >> 1;
					b_d  = (b_q - NW'(b_q[0])) >> 1;
				end else begin
					ea_d    = 1'b0;
					eb_d    = 1'b0;
					state_d = ST_Q_EMIT;
				end
			end
			ST_Q_EMIT: begin
				if (!rsp_valid_q || rsp.ready) begin
					sum_d       = cur_q;
					rsp_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ea_s1       <= 1'b0;
			eb_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			ea_s1       <= ea_d;
			eb_s1       <= eb_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		node_q  <= node_d;
		a_q     <= a_d;
		b_q     <= b_d;
		cur_q   <= cur_d;
		delta_q <= delta_d;
		sum_q   <= sum_d;
	end

	// The query ends never cross while the walk is running.
	`RSTA_ASSERT(a_query_order, clk, arst_n, (state_q == ST_Q_RUN) |-> (a_q <= b_q))
	// The update walk never climbs above the root.
	`RSTA_ASSERT(a_upd_below_root, clk, arst_n, (state_q == ST_UPD_UP) |-> (node_q[AW-1:1] != '0))
	// A response is only raised by the emit step of a query.
	`RSTA_ASSERT(a_rsp_from_emit, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == ST_Q_EMIT))
	// No node is written while waiting for a transaction.
	`RSTA_NEVER(a_no_idle_write, clk, arst_n, (state_q == ST_IDLE) && mem_we)

endmodule

### tb/testbench.sv
// Self-checking testbench for the range sum tree with point updates and range queries.
`timescale 1ns / 1ps
module testbench;
	import rsta_pkg::*;

	localparam int LEAVES           = LEAVES_DEF;
	localparam int NODE_AW          = $clog2(2 * LEAVES);
	localparam int QUIET_LIMIT      = 12000;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES     = 32;

	typedef struct packed {
		logic                      mode;
		logic [POS_W-1:0]          position;
		logic [POS_W-1:0]          right;
		logic signed [DELTA_W-1:0] delta;
	} tree_item_t;

	logic clk;
	logic arst_n;

	rsta_req_if req_ch ();
	rsta_rsp_if rsp_ch ();

	range_sum_tree_point_add #(
		.LEAVES(LEAVES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Local copy of the node sums, laid out bottom-up with leaves at LEAVES..2*LEAVES-1.
	logic [SUM_W-1:0] node_sum [2*LEAVES];
	logic [SUM_W-1:0] sum_expected [$];

	bit          idling_on;
	bit          long_hold_req;
	int unsigned mismatch_count;
	int unsigned updates_sent;
	int unsigned queries_sent;
	int unsigned sums_checked;

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Adds a sign-extended delta at one leaf and refreshes every enclosing node.
	function automatic void tree_add(int unsigned pos, logic signed [DELTA_W-1:0] amount);
		int unsigned node;
		if (pos >= LEAVES)
			return;
		node = pos + LEAVES;
		node_sum[NODE_AW'(node)] = node_sum[NODE_AW'(node)]
			+ {{(SUM_W-DELTA_W){amount[DELTA_W-1]}}, amount};
		while (node > 1) begin
			node_sum[NODE_AW'(node >> 1)] = node_sum[NODE_AW'(node)]
				+ node_sum[NODE_AW'(node ^ 1)];
			node = node >> 1;
		end
	endfunction

	// Wrapped sum of the leaves lo..hi, zero for an empty or out-of-range span.
	function automatic logic [SUM_W-1:0] tree_range_sum(int unsigned lo, int unsigned hi);
		logic [SUM_W-1:0] total;
		int unsigned      a;
		int unsigned      b;
		total = '0;
		if (lo >= LEAVES)
			return '0;
		if (hi >= LEAVES)
			hi = LEAVES - 1;
		if (lo > hi)
			return '0;
		a = lo + LEAVES;
		b = hi + 1 + LEAVES;
		while (a < b) begin
			if (a[0]) begin
				total = total + node_sum[NODE_AW'(a)];
				a++;
			end
			if (b[0]) begin
				b--;
				total = total + node_sum[NODE_AW'(b)];
			end
			a = a >> 1;
			b = b >> 1;
		end
		return total;
	endfunction

	// Biased position: the ends of the tree, a small crowded corner, or anywhere.
	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return POS_W'(LEAVES - 1);
			2, 3: return POS_W'($urandom_range(0, 15));
			default: return POS_W'($urandom_range(0, LEAVES - 1));
		endcase
	endfunction

	// Random update or query, mostly with ordered query ends.
	function automatic tree_item_t random_item(int unsigned query_pct);
		tree_item_t       item;
		logic [POS_W-1:0] swap_pos;
		item.mode     = ($urandom_range(0, 99) < query_pct) ? MODE_QUERY : MODE_UPDATE;
		item.position = pick_position();
		item.right    = pick_position();
		case ($urandom_range(0, 11))
			0: item.delta = {1'b0, {(DELTA_W-1){1'b1}}};
			1: item.delta = {1'b1, {(DELTA_W-1){1'b0}}};
			default: item.delta = DELTA_W'($urandom);
		endcase
		if (item.right < item.position && $urandom_range(0, 9) < 8) begin
			swap_pos      = item.right;
			item.right    = item.position;
			item.position = swap_pos;
		end
		return item;
	endfunction

	// Offers one transaction, optionally after a gap, and records its expected result.
	task automatic send_item(tree_item_t item);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= item.mode;
		req_ch.position <= item.position;
		req_ch.right    <= item.right;
		req_ch.delta    <= item.delta;
		do
			@(posedge clk);
		while (!req_ch.ready);
		if (item.mode == MODE_UPDATE) begin
			tree_add(32'(item.position), item.delta);
			updates_sent++;
		end else begin
			sum_expected.insert(sum_expected.size(),
				tree_range_sum(32'(item.position), 32'(item.right)));
			queries_sent++;
		end
	endtask

	task automatic send_update(int unsigned pos, logic signed [DELTA_W-1:0] amount);
		tree_item_t item;
		item = random_item(0);
		item.mode     = MODE_UPDATE;
		item.position = POS_W'(pos);
		item.delta    = amount;
		send_item(item);
	endtask

	task automatic send_query(int unsigned lo, int unsigned hi);
		tree_item_t item;
		item = random_item(100);
		item.mode     = MODE_QUERY;
		item.position = POS_W'(lo);
		item.right    = POS_W'(hi);
		send_item(item);
	endtask

	// Extreme deltas at the tree ends, full and single-point ranges, and reversed ranges.
	task automatic test_directed();
		send_query(0, LEAVES - 1);
		send_update(0, 16'sh7fff);
		send_update(LEAVES - 1, -16'sh8000);
		send_update(LEAVES / 2, -16'sh0001);
		send_update(LEAVES / 2 - 1, 16'sh0001);
		send_update(1, 16'sh7fff);
		send_query(0, LEAVES - 1);
		send_query(0, 0);
		send_query(LEAVES - 1, LEAVES - 1);
		send_query(LEAVES / 2 - 1, LEAVES / 2);
		send_query(LEAVES / 2, LEAVES - 1);
		send_query(0, LEAVES / 2 - 1);
		send_query(LEAVES - 1, 0);
		send_query(5, 4);
		send_query(1, 1);
		send_query(2, LEAVES - 2);
		send_update(0, -16'sh8000);
		send_update(0, -16'sh8000);
		send_query(0, 1);
		send_query(0, LEAVES - 1);
		send_update(LEAVES - 1, 16'sh0000);
		send_query(LEAVES - 2, LEAVES - 1);
	endtask

	// Mixed random updates and queries with idling on both channels.
	task automatic test_random_mix(int unsigned count);
		repeat (count) send_item(random_item(50));
	endtask

	// The receiver holds off for a long stretch while queries keep coming, so the block stalls.
	task automatic test_output_stall();
		long_hold_req = 1'b1;
		repeat (60) send_item(random_item(70));
		wait (!long_hold_req);
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_full_rate(int unsigned count);
		idling_on = 1'b0;
		repeat (count) send_item(random_item(50));
	endtask

	// Output side pacing: random stall bursts, or one long hold when asked for.
	initial begin : sum_sink_pacing
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compares each returned sum with the oldest expected one.
	always @(posedge clk) begin : sum_checker
		logic [SUM_W-1:0] want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (sum_expected.size() == 0) begin
				$error("sum: expected none, actual %0d", rsp_ch.sum);
				mismatch_count++;
			end else begin
				want = sum_expected.pop_front();
				sums_checked++;
				if (rsp_ch.sum !== want) begin
					$error("sum: expected %0d, actual %0d", $signed(want), rsp_ch.sum);
					mismatch_count++;
				end
			end
		end
	end

	// Ends the run when no transaction moves on either channel for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	// Reset, the test sequence, the drain and the verdict.
	initial begin : main_sequence
		req_ch.valid    = 1'b0;
		req_ch.mode     = MODE_UPDATE;
		req_ch.position = '0;
		req_ch.right    = '0;
		req_ch.delta    = '0;
		arst_n          = 1'b0;
		idling_on       = 1'b1;
		long_hold_req   = 1'b0;
		mismatch_count  = 0;
		updates_sent    = 0;
		queries_sent    = 0;
		sums_checked    = 0;
		foreach (node_sum[i])
			node_sum[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(750);
		test_output_stall();
		test_full_rate(320);

		req_ch.valid <= 1'b0;
		while (sum_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d updates and %0d queries; %0d range sums compared,",
			updates_sent, queries_sent, sums_checked);
		$display("including reversed and single-point ranges and a long output stall.");
		if (mismatch_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
